[design/rcr_pkg.sv]
// ----------------------------------------------------------------------------
// rcr_pkg
// Shared widths, codes and types for the reflectance array steering block.
// ----------------------------------------------------------------------------
package rcr_pkg;

   // Array size and tick counter width.
   localparam int NUM_SENSORS     = 8;
   localparam int TIME_WIDTH      = 16;

   // Fixed field widths of the ports.
   localparam int LEVEL_WIDTH     = 8;
   localparam int HOLD_WIDTH      = 8;
   localparam int THRESH_WIDTH    = 16;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int PHASE_WIDTH     = 2;
   localparam int CMD_WIDTH       = 3;
   localparam int MAP_WIDTH       = 8;
   localparam int COUNT_OUT_WIDTH = 3;

   // Reset values of the configuration registers.
   localparam logic [HOLD_WIDTH-1:0]   HOLD_TICKS_RESET      = HOLD_WIDTH'(1);
   localparam logic [THRESH_WIDTH-1:0] BLACK_THRESHOLD_RESET = THRESH_WIDTH'(2);

   // Derived sizes.
   localparam int HALF_SENSORS = NUM_SENSORS / 2;
   localparam int COUNT_WIDTH  = $clog2(NUM_SENSORS + 1);
   localparam int MAP_LANES    = (NUM_SENSORS < MAP_WIDTH) ? NUM_SENSORS : MAP_WIDTH;
   localparam int IN_LANES     = (NUM_SENSORS < LEVEL_WIDTH) ? NUM_SENSORS : LEVEL_WIDTH;
   localparam int CMP_WIDTH    = (TIME_WIDTH > THRESH_WIDTH) ? TIME_WIDTH : THRESH_WIDTH;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_HOLD_TICKS      = 1'b0,
      CSR_BLACK_THRESHOLD = 1'b1
   } csr_index_type;

   // Steer command codes.
   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_STRAIGHT   = 3'd0,
      CMD_LEFT       = 3'd1,
      CMD_RIGHT      = 3'd2,
      CMD_STOP_BLACK = 3'd3,
      CMD_STOP_NONE  = 3'd4
   } cmd_type;

   // Control sent from the sequencer to every lane.
   typedef struct packed {
      logic                    clear;
      logic                    capture;
      logic [TIME_WIDTH-1:0]   tick;
      logic [TIME_WIDTH-1:0]   mark;
      logic [THRESH_WIDTH-1:0] threshold;
   } lane_ctrl_type;

   // What one lane reports for the current tick.
   typedef struct packed {
      logic done;
      logic black;
   } lane_status_type;

   // Steering decision for one tick.
   typedef struct packed {
      logic                       command_valid;
      logic [CMD_WIDTH-1:0]       steer_command;
      logic [MAP_WIDTH-1:0]       black_map;
      logic [COUNT_OUT_WIDTH-1:0] left_black;
      logic [COUNT_OUT_WIDTH-1:0] right_black;
   } decision_type;

   // One complete result item.
   typedef struct packed {
      logic                   charge_drive;
      logic [PHASE_WIDTH-1:0] phase;
      decision_type           decision;
   } rsp_type;

   // Clamp a black count to the output field.
   function automatic logic [COUNT_OUT_WIDTH-1:0] sat_count(input logic [COUNT_WIDTH-1:0] c);
      logic [COUNT_WIDTH+COUNT_OUT_WIDTH-1:0] wide;
      wide = (COUNT_WIDTH+COUNT_OUT_WIDTH)'(c);
      if (wide > (COUNT_WIDTH+COUNT_OUT_WIDTH)'(7)) begin
         return COUNT_OUT_WIDTH'(7);
      end
      return wide[COUNT_OUT_WIDTH-1:0];
   endfunction

endpackage

[design/rcr_lane.sv]
// ----------------------------------------------------------------------------
// rcr_lane
// One sensor channel: captures the first low tick of a read and classifies
// the discharge time against the black threshold.
// ----------------------------------------------------------------------------
module rcr_lane (
   input  logic                     clock,
   input  logic                     reset,
   input  rcr_pkg::lane_ctrl_type   ctrl,
   input  logic                     level,
   output rcr_pkg::lane_status_type status
);
   import rcr_pkg::*;

   logic                  captured_ff;
   logic                  captured_in;
   logic [TIME_WIDTH-1:0] cap_tick_ff;
   logic [TIME_WIDTH-1:0] cap_tick_in;
   logic [TIME_WIDTH-1:0] cap_value;
   logic [TIME_WIDTH-1:0] delta;

   // Capture flag and capture tick.
   always_comb begin
      captured_in = captured_ff;
      cap_tick_in = cap_tick_ff;
      if (ctrl.clear) begin
         captured_in = 1'b0;
      end else if (ctrl.capture && !captured_ff && !level) begin
         captured_in = 1'b1;
         cap_tick_in = ctrl.tick;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         captured_ff <= 1'b0;
      end else begin
         captured_ff <= captured_in;
      end
   end

   always_ff @(posedge clock) begin
      cap_tick_ff <= cap_tick_in;
   end

   // A pin that goes low on this tick counts as captured at this tick.
   assign cap_value = captured_ff ? cap_tick_ff : ctrl.tick;
   assign delta     = cap_value - ctrl.mark;

   assign status.done  = captured_ff | ~level;
   assign status.black = CMP_WIDTH'(delta) > CMP_WIDTH'(ctrl.threshold);

endmodule

[design/rcr_merge.sv]
// ----------------------------------------------------------------------------
// rcr_merge
// Combines the lane results: black map, per-half counts and steer command.
// Holds the last issued command.
// ----------------------------------------------------------------------------
module rcr_merge (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         issue,
   input  logic [rcr_pkg::NUM_SENSORS-1:0] black,
   output rcr_pkg::decision_type        decision
);
   import rcr_pkg::*;

   logic [CMD_WIDTH-1:0]   last_cmd_ff;
   logic [CMD_WIDTH-1:0]   last_cmd_in;
   logic [COUNT_WIDTH-1:0] left_cnt;
   logic [COUNT_WIDTH-1:0] right_cnt;
   logic [CMD_WIDTH-1:0]   cmd;
   logic [MAP_WIDTH-1:0]   map;

   // Count black sensors in each half.
   always_comb begin
      left_cnt  = '0;
      right_cnt = '0;
      for (int i = 0; i < NUM_SENSORS; i++) begin
         if (i < HALF_SENSORS) begin
            left_cnt = left_cnt + COUNT_WIDTH'(black[i]);
         end else begin
            right_cnt = right_cnt + COUNT_WIDTH'(black[i]);
         end
      end
   end

   // Decision in priority order.
   always_comb begin
      if (&black) begin
         cmd = CMD_STOP_BLACK;
      end else if (left_cnt > right_cnt) begin
         cmd = CMD_LEFT;
      end else if (right_cnt > left_cnt) begin
         cmd = CMD_RIGHT;
      end else if (left_cnt == '0) begin
         cmd = CMD_STOP_NONE;
      end else begin
         cmd = CMD_STRAIGHT;
      end
   end

   always_comb begin
      map                  = '0;
      map[MAP_LANES-1:0]   = black[MAP_LANES-1:0];
   end

   assign last_cmd_in = issue ? cmd : last_cmd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_cmd_ff <= CMD_STOP_NONE;
      end else begin
         last_cmd_ff <= last_cmd_in;
      end
   end

   // Fields other than the command read zero when no command is issued.
   always_comb begin
      decision.command_valid = issue;
      decision.steer_command = last_cmd_in;
      decision.black_map     = issue ? map : '0;
      decision.left_black    = issue ? sat_count(left_cnt) : '0;
      decision.right_black   = issue ? sat_count(right_cnt) : '0;
   end

endmodule

[design/rc_reflectance_array_steering_top.sv]
// ----------------------------------------------------------------------------
// rc_reflectance_array_steering_top
// Charge / hold / read sequencer for an RC reflectance sensor array, with one
// lane per sensor and a merge stage that forms the steer command.
//
//   Channel   Direction  Handshake          Content
//   req_      in         req_valid/stall    one tick: sensor pin levels
//   rsp_      out        rsp_valid/stall    one result per tick
//   csr_      in         csr_write          hold_ticks, black_threshold
//
// One tick is taken per clock cycle while req_stall is low; each produces
// exactly one result, held in the output register or, when that is full, in
// the skid entry. The lanes, merge and sequencer update in the transfer cycle.
// A two-entry output buffer (register plus skid) keeps input transfers going
// while a result waits; req_stall rises only when both entries are full.
// Reset is synchronous and returns the sequencer to the charge phase.
// ----------------------------------------------------------------------------
module rc_reflectance_array_steering_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [rcr_pkg::LEVEL_WIDTH-1:0]      req_sensor_levels,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_charge_drive,
   output logic [rcr_pkg::PHASE_WIDTH-1:0]      rsp_phase,
   output logic                                 rsp_command_valid,
   output logic [rcr_pkg::CMD_WIDTH-1:0]        rsp_steer_command,
   output logic [rcr_pkg::MAP_WIDTH-1:0]        rsp_black_map,
   output logic [rcr_pkg::COUNT_OUT_WIDTH-1:0]  rsp_left_black,
   output logic [rcr_pkg::COUNT_OUT_WIDTH-1:0]  rsp_right_black,
   input  logic                                 csr_write,
   input  rcr_pkg::csr_index_type               csr_index,
   input  logic [rcr_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);
   import rcr_pkg::*;

   typedef enum logic [PHASE_WIDTH-1:0] {
      PH_CHARGE = 2'd0,
      PH_HOLD   = 2'd1,
      PH_READ   = 2'd2
   } phase_type;

   phase_type                 phase_ff;
   phase_type                 phase_in;
   logic [TIME_WIDTH-1:0]     tick_ff;
   logic [TIME_WIDTH-1:0]     tick_in;
   logic [TIME_WIDTH-1:0]     mark_ff;
   logic [TIME_WIDTH-1:0]     mark_in;
   logic [TIME_WIDTH-1:0]     elapsed;
   logic [HOLD_WIDTH-1:0]     hold_ticks_ff;
   logic [THRESH_WIDTH-1:0]   black_threshold_ff;

   logic                      req_fire;
   logic                      rsp_fire;
   logic                      all_done;
   logic                      issue;
   lane_ctrl_type             lane_ctrl;
   lane_status_type           lane_status [NUM_SENSORS];
   logic [NUM_SENSORS-1:0]    lane_done;
   logic [NUM_SENSORS-1:0]    lane_black;
   decision_type              decision;
   rsp_type                   rsp_in;

   rsp_type                   main_ff;
   logic                      main_valid_ff;
   rsp_type                   skid_ff;
   logic                      skid_valid_ff;

   assign req_fire = req_valid & ~req_stall;
   assign rsp_fire = rsp_valid & ~rsp_stall;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ticks_ff      <= HOLD_TICKS_RESET;
         black_threshold_ff <= BLACK_THRESHOLD_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_HOLD_TICKS:      hold_ticks_ff      <= csr_data[HOLD_WIDTH-1:0];
            CSR_BLACK_THRESHOLD: black_threshold_ff <= csr_data[THRESH_WIDTH-1:0];
            default:             hold_ticks_ff      <= hold_ticks_ff;
         endcase
      end
   end

   // Lane control for this tick.
   always_comb begin
      lane_ctrl.clear     = req_fire && (phase_ff != PH_HOLD) && (phase_ff != PH_READ);
      lane_ctrl.capture   = req_fire && (phase_ff == PH_READ);
      lane_ctrl.tick      = tick_ff;
      lane_ctrl.mark      = mark_ff;
      lane_ctrl.threshold = black_threshold_ff;
   end

   // One lane per sensor; sensors past the input port read low.
   for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_lane
      logic level;
      if (g < IN_LANES) begin : g_pin
         assign level = req_sensor_levels[g];
      end else begin : g_tied
         assign level = 1'b0;
      end
      rcr_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (lane_ctrl),
         .level  (level),
         .status (lane_status[g])
      );
      assign lane_done[g]  = lane_status[g].done;
      assign lane_black[g] = lane_status[g].black;
   end

   assign all_done = &lane_done;
   assign issue    = req_fire && (phase_ff == PH_READ) && all_done;

   rcr_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .issue    (issue),
      .black    (lane_black),
      .decision (decision)
   );

   // Phase sequencer next state.
   assign elapsed = tick_ff - mark_ff;

   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      mark_in  = mark_ff;
      if (req_fire) begin
         tick_in = tick_ff + TIME_WIDTH'(1);
         case (phase_ff)
            PH_HOLD: begin
               if (elapsed >= TIME_WIDTH'(hold_ticks_ff)) begin
                  mark_in  = tick_ff;
                  phase_in = PH_READ;
               end
            end
            PH_READ: begin
               if (all_done) begin
                  phase_in = PH_CHARGE;
               end
            end
            default: begin
               mark_in  = tick_ff;
               phase_in = PH_HOLD;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_CHARGE;
         tick_ff  <= '0;
         mark_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         mark_ff  <= mark_in;
      end
   end

   // Result for the tick being transferred in.
   always_comb begin
      rsp_in.charge_drive = (phase_ff != PH_READ);
      rsp_in.phase        = (phase_ff == PH_HOLD || phase_ff == PH_READ) ? phase_ff : PH_CHARGE;
      rsp_in.decision     = decision;
   end

   // Output register with skid entry.
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_fire) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (!main_valid_ff || rsp_fire) begin
         main_valid_ff <= req_fire;
      end else if (req_fire) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_fire) begin
            main_ff <= skid_ff;
         end
      end else if (!main_valid_ff || rsp_fire) begin
         main_ff <= rsp_in;
      end else if (req_fire) begin
         skid_ff <= rsp_in;
      end
   end

   assign req_stall         = skid_valid_ff;
   assign rsp_valid         = main_valid_ff;
   assign rsp_charge_drive  = main_ff.charge_drive;
   assign rsp_phase         = main_ff.phase;
   assign rsp_command_valid = main_ff.decision.command_valid;
   assign rsp_steer_command = main_ff.decision.steer_command;
   assign rsp_black_map     = main_ff.decision.black_map;
   assign rsp_left_black    = main_ff.decision.left_black;
   assign rsp_right_black   = main_ff.decision.right_black;

   // The skid entry is only used behind a full output register.
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry full while output register empty");

   // A steer command only completes a read.
   a_cmd_in_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_command_valid) |-> (rsp_phase == PH_READ && !rsp_charge_drive))
      else $error("command issued outside the read phase");

   // Without a command the map and counts read zero.
   a_idle_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_command_valid) |->
         (rsp_black_map == '0 && rsp_left_black == '0 && rsp_right_black == '0))
      else $error("map or counts set without a command");

   // Issuing a command returns the sequencer to charge.
   a_issue_to_charge: assert property (@(posedge clock) disable iff (reset)
      issue |=> (phase_ff == PH_CHARGE))
      else $error("sequencer did not return to charge after a command");

endmodule

[test/rc_reflectance_array_steering_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rc_reflectance_array_steering_checker
// Watches the tick, result and register ports of the steering block. It keeps
// its own copy of the charge / hold / read sequencer, predicts the result of
// every accepted tick and compares each result transfer with the oldest
// prediction. It also tells the stimulus whether the next tick falls in the
// read phase, so that discharge patterns line up with the release of the pins.
// ----------------------------------------------------------------------------
module rc_reflectance_array_steering_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic [rcr_pkg::LEVEL_WIDTH-1:0]      req_sensor_levels,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic                                 rsp_charge_drive,
   input  logic [rcr_pkg::PHASE_WIDTH-1:0]      rsp_phase,
   input  logic                                 rsp_command_valid,
   input  logic [rcr_pkg::CMD_WIDTH-1:0]        rsp_steer_command,
   input  logic [rcr_pkg::MAP_WIDTH-1:0]        rsp_black_map,
   input  logic [rcr_pkg::COUNT_OUT_WIDTH-1:0]  rsp_left_black,
   input  logic [rcr_pkg::COUNT_OUT_WIDTH-1:0]  rsp_right_black,
   input  logic                                 csr_write,
   input  rcr_pkg::csr_index_type               csr_index,
   input  logic [rcr_pkg::CSR_DATA_WIDTH-1:0]   csr_data,
   output int                                   mismatches,
   output int                                   pending,
   output logic                                 next_is_read,
   output int                                   ticks_checked,
   output int                                   commands_checked,
   output logic [4:0]                           command_kinds
);
   import rcr_pkg::*;

   typedef enum logic [PHASE_WIDTH-1:0] {
      PH_CHARGE = 2'd0,
      PH_HOLD   = 2'd1,
      PH_READ   = 2'd2
   } phase_type;

   // Everything the sequencer remembers from one tick to the next.
   typedef struct packed {
      logic [TIME_WIDTH-1:0]                   tick;
      phase_type                               phase;
      logic [TIME_WIDTH-1:0]                   mark;
      logic [NUM_SENSORS-1:0]                  flags;
      logic [NUM_SENSORS-1:0][TIME_WIDTH-1:0]  caps;
      cmd_type                                 last;
   } scan_state_type;

   scan_state_type          scan_model;
   logic [HOLD_WIDTH-1:0]   hold_cfg;
   logic [THRESH_WIDTH-1:0] thresh_cfg;
   rsp_type                 due_results [$];

   // One tick of the sequencer: returns the next state and the result it causes.
   function automatic scan_state_type advance_tick(input scan_state_type s,
                                                   input logic [LEVEL_WIDTH-1:0] lv,
                                                   input logic [HOLD_WIDTH-1:0] hold,
                                                   input logic [THRESH_WIDTH-1:0] thr,
                                                   output rsp_type res);
      scan_state_type        n;
      phase_type             cur;
      logic [TIME_WIDTH-1:0] span;
      logic [MAP_WIDTH-1:0]  map;
      int                    n_left;
      int                    n_right;
      logic                  done;
      n       = s;
      cur     = s.phase;
      map     = '0;
      n_left  = 0;
      n_right = 0;
      done    = 1'b0;
      case (cur)
         PH_HOLD: begin
            // Release once the hold time has passed, modulo the tick width.
            span = s.tick - s.mark;
            if (span >= TIME_WIDTH'(hold)) begin
               n.mark  = s.tick;
               n.phase = PH_READ;
            end
         end
         PH_READ: begin
            // Only the first low level of each sensor counts.
            for (int i = 0; i < NUM_SENSORS; i++) begin
               if (!n.flags[i] && !lv[i]) begin
                  n.caps[i]  = s.tick;
                  n.flags[i] = 1'b1;
               end
            end
            if (&n.flags) begin
               for (int i = 0; i < NUM_SENSORS; i++) begin
                  span = n.caps[i] - s.mark;
                  if (span > thr) begin
                     map[i] = 1'b1;
                     if (i < HALF_SENSORS) begin
                        n_left++;
                     end else begin
                        n_right++;
                     end
                  end
               end
               if (n_left + n_right == NUM_SENSORS) begin
                  n.last = CMD_STOP_BLACK;
               end else if (n_left > n_right) begin
                  n.last = CMD_LEFT;
               end else if (n_right > n_left) begin
                  n.last = CMD_RIGHT;
               end else if (n_left == 0) begin
                  n.last = CMD_STOP_NONE;
               end else begin
                  n.last = CMD_STRAIGHT;
               end
               done    = 1'b1;
               n.phase = PH_CHARGE;
            end
         end
         default: begin
            // Charge, and the unused code behaves the same way.
            cur     = PH_CHARGE;
            n.mark  = s.tick;
            n.flags = '0;
            n.phase = PH_HOLD;
         end
      endcase
      res.charge_drive           = (cur != PH_READ);
      res.phase                  = cur;
      res.decision.command_valid = done;
      res.decision.steer_command = n.last;
      res.decision.black_map     = map;
      res.decision.left_black    = !done ? '0 : (n_left > 7) ? 3'd7 : 3'(n_left);
      res.decision.right_black   = !done ? '0 : (n_right > 7) ? 3'd7 : 3'(n_right);
      n.tick = s.tick + 1'b1;
      return n;
   endfunction

   // Phase of the next tick to be offered, counting a transfer under way.
   always @* begin : look_ahead
      rsp_type        unused_res;
      scan_state_type ahead;
      ahead = advance_tick(scan_model, req_sensor_levels, hold_cfg, thresh_cfg, unused_res);
      if (req_valid && !req_stall) begin
         next_is_read = (ahead.phase == PH_READ);
      end else begin
         next_is_read = (scan_model.phase == PH_READ);
      end
   end

   // Track register writes, predict each tick and compare each result.
   always @(posedge clock) begin : track
      rsp_type        got;
      rsp_type        want;
      scan_state_type fresh;
      if (reset) begin
         fresh       = '0;
         fresh.phase = PH_CHARGE;
         fresh.last  = CMD_STOP_NONE;
         scan_model       <= fresh;
         hold_cfg         <= HOLD_TICKS_RESET;
         thresh_cfg       <= BLACK_THRESHOLD_RESET;
         due_results.delete();
         pending          <= 0;
         mismatches       <= 0;
         ticks_checked    <= 0;
         commands_checked <= 0;
         command_kinds    <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_HOLD_TICKS:      hold_cfg   <= csr_data[HOLD_WIDTH-1:0];
               CSR_BLACK_THRESHOLD: thresh_cfg <= csr_data[THRESH_WIDTH-1:0];
               default:             ;
            endcase
         end

         if (rsp_valid && !rsp_stall) begin
            got.charge_drive           = rsp_charge_drive;
            got.phase                  = rsp_phase;
            got.decision.command_valid = rsp_command_valid;
            got.decision.steer_command = rsp_steer_command;
            got.decision.black_map     = rsp_black_map;
            got.decision.left_black    = rsp_left_black;
            got.decision.right_black   = rsp_right_black;
            if (due_results.size() == 0) begin
               if (mismatches < 10) begin
                  $display("ERROR: result transfer with no tick waiting: drive=%0d phase=%0d",
                           got.charge_drive, got.phase);
               end
               mismatches <= mismatches + 1;
            end else begin
               want = due_results.pop_front();
               ticks_checked <= ticks_checked + 1;
               if (want.decision.command_valid) begin
                  commands_checked <= commands_checked + 1;
                  command_kinds[want.decision.steer_command] <= 1'b1;
               end
               if (got !== want) begin
                  if (mismatches < 10) begin
                     $display({"ERROR: result %0d expected drive=%0d phase=%0d valid=%0d",
                               " cmd=%0d map=%02h left=%0d right=%0d"},
                              ticks_checked, want.charge_drive, want.phase,
                              want.decision.command_valid, want.decision.steer_command,
                              want.decision.black_map, want.decision.left_black,
                              want.decision.right_black);
                     $display({"       got      drive=%0d phase=%0d valid=%0d",
                               " cmd=%0d map=%02h left=%0d right=%0d"},
                              got.charge_drive, got.phase, got.decision.command_valid,
                              got.decision.steer_command, got.decision.black_map,
                              got.decision.left_black, got.decision.right_black);
                  end
                  mismatches <= mismatches + 1;
               end
            end
         end

         if (req_valid && !req_stall) begin
            scan_model <= advance_tick(scan_model, req_sensor_levels, hold_cfg, thresh_cfg,
                                       want);
            due_results.push_back(want);
         end

         pending <= due_results.size();
      end
   end

endmodule

[test/rc_reflectance_array_steering_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rc_reflectance_array_steering_top_tb
// Drives sensor ticks and register writes into the steering block. A short
// directed part produces each steer command at the reset settings; random
// scans follow over several hold and threshold settings, including the
// extremes, a receiver hold-off that backs the block up and a stretch without
// idling. Checking is done by the checker instance.
// ----------------------------------------------------------------------------
module rc_reflectance_array_steering_top_tb;
   import rcr_pkg::*;

   localparam int IDLE_PCT       = 7;
   localparam int HOLDOFF_CYCLES = 60;
   localparam int CYCLE_LIMIT    = 1000000;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic [LEVEL_WIDTH-1:0]      req_sensor_levels;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic                        rsp_charge_drive;
   logic [PHASE_WIDTH-1:0]      rsp_phase;
   logic                        rsp_command_valid;
   logic [CMD_WIDTH-1:0]        rsp_steer_command;
   logic [MAP_WIDTH-1:0]        rsp_black_map;
   logic [COUNT_OUT_WIDTH-1:0]  rsp_left_black;
   logic [COUNT_OUT_WIDTH-1:0]  rsp_right_black;
   logic                        csr_write;
   csr_index_type               csr_index;
   logic [CSR_DATA_WIDTH-1:0]   csr_data;

   int                          mismatches;
   int                          pending;
   logic                        next_is_read;
   int                          ticks_checked;
   int                          commands_checked;
   logic [4:0]                  command_kinds;

   bit                          calm;
   int                          holdoff_req;
   int                          ticks_sent;
   int                          settings_used;
   int unsigned                 drop_at [NUM_SENSORS];

   rc_reflectance_array_steering_top DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sensor_levels (req_sensor_levels),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_charge_drive  (rsp_charge_drive),
      .rsp_phase         (rsp_phase),
      .rsp_command_valid (rsp_command_valid),
      .rsp_steer_command (rsp_steer_command),
      .rsp_black_map     (rsp_black_map),
      .rsp_left_black    (rsp_left_black),
      .rsp_right_black   (rsp_right_black),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   rc_reflectance_array_steering_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sensor_levels (req_sensor_levels),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_charge_drive  (rsp_charge_drive),
      .rsp_phase         (rsp_phase),
      .rsp_command_valid (rsp_command_valid),
      .rsp_steer_command (rsp_steer_command),
      .rsp_black_map     (rsp_black_map),
      .rsp_left_black    (rsp_left_black),
      .rsp_right_black   (rsp_right_black),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .mismatches        (mismatches),
      .pending           (pending),
      .next_is_read      (next_is_read),
      .ticks_checked     (ticks_checked),
      .commands_checked  (commands_checked),
      .command_kinds     (command_kinds)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side: random stalls, or a long hold-off when one is requested.
   initial begin : result_stall
      int served;
      served = 0;
      forever begin
         if (holdoff_req != served) begin
            served++;
            rsp_stall <= 1'b1;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
            @(posedge clock);
         end
      end
   end

   // Watchdog on the whole run.
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("ERROR: run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("status: fail");
      $finish;
   end

   // Offer one tick, with random idle cycles ahead of it, and wait for the transfer.
   task automatic send_tick(input logic [LEVEL_WIDTH-1:0] lv);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_sensor_levels <= lv;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ticks_sent++;
   endtask

   // Write one register once every predicted result has arrived.
   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_WIDTH-1:0] val);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // One charge / hold / read cycle. Pins stay high until their drop tick,
   // counted from the first read tick; a noisy scan toggles pins at random.
   task automatic run_scan(input bit noisy);
      int unsigned            t;
      logic [LEVEL_WIDTH-1:0] lv;
      t = 0;
      while (!next_is_read) send_tick(LEVEL_WIDTH'($urandom));
      while (next_is_read) begin
         for (int i = 0; i < NUM_SENSORS; i++) begin
            lv[i] = (t < drop_at[i]);
         end
         if (noisy) begin
            lv = LEVEL_WIDTH'($urandom);
         end
         send_tick(lv);
         t++;
      end
   endtask

   // Drop ticks for a directed scan, one nibble per sensor.
   task automatic load_drops(input logic [31:0] nibbles);
      for (int i = 0; i < NUM_SENSORS; i++) begin
         drop_at[i] = nibbles[4*i +: 4];
      end
   endtask

   // One register setting followed by random scans.
   task automatic run_phase(input logic [HOLD_WIDTH-1:0] hold,
                            input logic [THRESH_WIDTH-1:0] thr,
                            input int n_ticks, input int noise_pct, input bit squeeze);
      int spread;
      int first;
      int shape;
      write_csr(CSR_HOLD_TICKS, CSR_DATA_WIDTH'(hold));
      write_csr(CSR_BLACK_THRESHOLD, CSR_DATA_WIDTH'(thr));
      settings_used++;
      if (squeeze) begin
         holdoff_req++;
      end
      spread = (thr > 20) ? 20 : int'(thr);
      first  = ticks_sent;
      while (ticks_sent - first < n_ticks) begin
         shape = $urandom_range(7);
         for (int i = 0; i < NUM_SENSORS; i++) begin
            if (shape == 0) begin
               drop_at[i] = 0;
            end else if (shape == 1) begin
               drop_at[i] = $urandom_range(spread + 1, 2 * spread + 3);
            end else begin
               drop_at[i] = $urandom_range(0, 2 * spread + 3);
            end
         end
         run_scan($urandom_range(99) < noise_pct);
      end
   endtask

   // Stimulus and verdict.
   initial begin : stimulus
      int waited;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_sensor_levels = '0;
      csr_write         = 1'b0;
      csr_index         = CSR_HOLD_TICKS;
      csr_data          = '0;
      calm              = 1'b0;
      holdoff_req       = 0;
      ticks_sent        = 0;
      settings_used     = 1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: a sensor is black when it stays high two read ticks.
      load_drops(32'h0000_0000);
      run_scan(1'b0);
      load_drops(32'h2222_2222);
      run_scan(1'b0);
      load_drops(32'h0000_3333);
      run_scan(1'b0);
      load_drops(32'h3300_0000);
      run_scan(1'b0);
      load_drops(32'h2000_0002);
      run_scan(1'b0);

      // Random scans over a range of settings, extremes included.
      run_phase(8'd0, 16'd0, 150, 10, 1'b0);
      run_phase(8'd2, 16'd3, 250, 10, 1'b0);
      run_phase(8'd255, 16'hFFFF, 260, 0, 1'b0);
      run_phase(HOLD_WIDTH'($urandom_range(0, 7)), THRESH_WIDTH'($urandom_range(0, 12)),
                300, 15, 1'b1);
      calm = 1'b1;
      run_phase(8'd1, 16'd6, 300, 5, 1'b0);
      calm = 1'b0;
      run_phase(8'd7, 16'd9, 150, 10, 1'b0);

      // Drain the remaining results.
      req_valid <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (pending != 0 && waited < 500) begin
         @(posedge clock);
         waited++;
      end
      repeat (5) @(posedge clock);

      $display("Checked %0d tick results and %0d steer commands over %0d register settings.",
               ticks_checked, commands_checked, settings_used);
      $display("Steer codes seen (one bit per code, code 0 rightmost): %05b", command_kinds);
      if (pending != 0) begin
         $display("ERROR: %0d results never arrived", pending);
      end
      if (mismatches == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
